/* design/igcd_pkg.sv */
package igcd_pkg;

   localparam int COORD_WIDTH    = 64;
   localparam int FIELD_WIDTH    = 64;
   localparam int DIV_WIDTH      = 63;
   localparam int CNT_WIDTH      = $clog2(COORD_WIDTH);
   localparam int REQ_DATA_WIDTH = 2 * FIELD_WIDTH;
   localparam int RSP_DATA_WIDTH = ((2 * FIELD_WIDTH + DIV_WIDTH + 7) / 8) * 8;

   typedef logic [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type diff;
      logic      borrow;
   } sub_result_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type divisor;
   } core_result_type;

endpackage

/* design/igcd_sub.sv */
module igcd_sub (
   input  igcd_pkg::coord_type      op_a,
   input  igcd_pkg::coord_type      op_b,
   output igcd_pkg::sub_result_type result
);
   import igcd_pkg::*;

   logic [COORD_WIDTH:0] wide_diff;

   assign wide_diff     = {1'b0, op_a} - {1'b0, op_b};
   assign result.diff   = wide_diff[COORD_WIDTH-1:0];
   assign result.borrow = wide_diff[COORD_WIDTH];

endmodule

/* design/igcd_core.sv */
module igcd_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start_valid,
   output logic                      start_ready,
   input  igcd_pkg::coord_type       in_x,
   input  igcd_pkg::coord_type       in_y,
   output logic                      done_valid,
   input  logic                      done_ready,
   output igcd_pkg::core_result_type result
);
   import igcd_pkg::*;

   typedef enum logic [3:0] {
      IDLE, MAGX, MAGY, GCD, FIX, DIVX, DIVY, NEGX, NEGY, DONE
   } state_type;

   state_type            state_ff, state_in;
   coord_type            mx_ff, mx_in;
   coord_type            my_ff, my_in;
   coord_type            a_ff, a_in;
   coord_type            b_ff, b_in;
   coord_type            g_ff, g_in;
   coord_type            rem_ff, rem_in;
   logic [CNT_WIDTH-1:0] k_ff, k_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 neg_x_ff, neg_x_in;
   logic                 neg_y_ff, neg_y_in;
   logic                 flip_ff, flip_in;

   coord_type      sub_a, sub_b, rem_sh;
   sub_result_type sub;
   logic           dvd_msb;

   igcd_sub u_sub (
      .op_a   (sub_a),
      .op_b   (sub_b),
      .result (sub)
   );

   assign dvd_msb = (state_ff == DIVX) ? mx_ff[COORD_WIDTH-1] : my_ff[COORD_WIDTH-1];
   assign rem_sh  = {rem_ff[COORD_WIDTH-2:0], dvd_msb};

   always_comb begin
      case (state_ff)
         MAGX, NEGX: begin
            sub_a = '0;
            sub_b = mx_ff;
         end
         MAGY, NEGY: begin
            sub_a = '0;
            sub_b = my_ff;
         end
         GCD: begin
            sub_a = a_ff;
            sub_b = b_ff;
         end
         DIVX, DIVY: begin
            sub_a = rem_sh;
            sub_b = g_ff;
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      g_in     = g_ff;
      rem_in   = rem_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      neg_x_in = neg_x_ff;
      neg_y_in = neg_y_ff;
      flip_in  = flip_ff;
      case (state_ff)
         IDLE: begin
            if (start_valid) begin
               mx_in    = in_x;
               my_in    = in_y;
               neg_x_in = in_x[COORD_WIDTH-1];
               neg_y_in = in_y[COORD_WIDTH-1];
               flip_in  = in_x[COORD_WIDTH-1] || (in_x == '0 && in_y[COORD_WIDTH-1]);
               k_in     = '0;
               state_in = MAGX;
            end
         end
         MAGX: begin
            if (neg_x_ff) mx_in = sub.diff;
            state_in = MAGY;
         end
         MAGY: begin
            a_in = mx_ff;
            if (neg_y_ff) begin
               my_in = sub.diff;
               b_in  = sub.diff;
            end else begin
               b_in  = my_ff;
            end
            state_in = GCD;
         end
         GCD: begin
            if (a_ff == '0 || b_ff == '0) begin
               g_in     = a_ff | b_ff;
               state_in = FIX;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (!sub.borrow) begin
               a_in = sub.diff;
            end else begin
               a_in = b_ff;
               b_in = a_ff;
            end
         end
         FIX: begin
            if (g_ff == '0) begin
               state_in = DONE;
            end else if (k_ff == '0) begin
               rem_in   = '0;
               cnt_in   = '0;
               state_in = DIVX;
            end else begin
               g_in = g_ff << 1;
               k_in = k_ff - 1'b1;
            end
         end
         DIVX, DIVY: begin
            rem_in = sub.borrow ? rem_sh : sub.diff;
            if (state_ff == DIVX) mx_in = {mx_ff[COORD_WIDTH-2:0], !sub.borrow};
            else                  my_in = {my_ff[COORD_WIDTH-2:0], !sub.borrow};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(COORD_WIDTH - 1)) begin
               cnt_in   = '0;
               rem_in   = '0;
               state_in = (state_ff == DIVX) ? DIVY : NEGX;
            end
         end
         NEGX: begin
            if (neg_x_ff != flip_ff) mx_in = sub.diff;
            state_in = NEGY;
         end
         NEGY: begin
            if (neg_y_ff != flip_ff) my_in = sub.diff;
            state_in = DONE;
         end
         DONE: begin
            if (done_ready) state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      g_ff     <= g_in;
      rem_ff   <= rem_in;
      k_ff     <= k_in;
      cnt_ff   <= cnt_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      flip_ff  <= flip_in;
   end

   assign start_ready    = (state_ff == IDLE);
   assign done_valid     = (state_ff == DONE);
   assign result.x       = mx_ff;
   assign result.y       = my_ff;
   assign result.divisor = g_ff;

endmodule

/* design/integer_vector_gcd_reduce.sv */
// Per vector: magnitudes of x and y, binary GCD steps, restoring common factors of two,
// a bit-serial division of x and of y by the divisor, sign fix, then the result register;
// a zero vector skips the divisions and the sign fix.
// Throughput: one vector at a time; req_tready stays low while the vector is in work.
// All subtractions share one COORD_WIDTH-bit subtractor, so the steps run one after another.
// Synchronous active-high reset returns the sequencer to idle and empties the output register.
module integer_vector_gcd_reduce (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [igcd_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,  // in_x, in_y
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [igcd_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata   // out_x, out_y, common_divisor
);
   import igcd_pkg::*;

   logic                   done_valid, done_ready;
   core_result_type        result;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0] out_x_ff, out_x_in;
   logic [FIELD_WIDTH-1:0] out_y_ff, out_y_in;
   logic [DIV_WIDTH-1:0]   div_ff, div_in;
   logic [FIELD_WIDTH-1:0] div_wide;

   igcd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .start_valid (req_tvalid),
      .start_ready (req_tready),
      .in_x        (req_tdata[COORD_WIDTH-1:0]),
      .in_y        (req_tdata[FIELD_WIDTH +: COORD_WIDTH]),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .result      (result)
   );

   assign done_ready = !rsp_valid_ff || rsp_tready;
   assign div_wide   = FIELD_WIDTH'(result.divisor);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      div_in       = div_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         out_x_in     = FIELD_WIDTH'($signed(result.x));
         out_y_in     = FIELD_WIDTH'($signed(result.y));
         div_in       = div_wide[FIELD_WIDTH-1] ? '1 : div_wide[DIV_WIDTH-1:0];
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      div_ff   <= div_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - 2*FIELD_WIDTH - DIV_WIDTH){1'b0}},
                        div_ff, out_y_ff, out_x_ff};

   a_reset_idle: assert property (@(posedge clock) reset |=> req_tready)
      else $error("sequencer not idle after reset");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while a vector is in work");

   a_zero_divisor: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && div_ff == '0) |-> (out_x_ff == '0 && out_y_ff == '0))
      else $error("zero divisor with nonzero vector");

endmodule
